// File: rtl/sphere_overlap_insert_table_core_macros.svh
// Assertion helpers shared by the sphere table modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef SPHERE_OVERLAP_INSERT_TABLE_CORE_MACROS_SVH
`define SPHERE_OVERLAP_INSERT_TABLE_CORE_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define SOT_ASSERT_SAME(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("sphere table assertion violated");

// The condition must hold in the cycle after the trigger.
`define SOT_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("sphere table assertion violated");

`endif

// File: rtl/sot_pkg.sv
`timescale 1ns / 1ps

package sot_pkg;

    localparam int TABLE_DEPTH     = 256;
    localparam int COORD_WIDTH     = 20;
    localparam int RADIUS_WIDTH    = COORD_WIDTH - 1;
    localparam int ADDR_WIDTH      = $clog2(TABLE_DEPTH);
    localparam int COUNT_WIDTH     = $clog2(TABLE_DEPTH + 1);
    localparam int OUT_COUNT_WIDTH = 9;
    localparam int SQ_WIDTH        = 2 * COORD_WIDTH;
    localparam int SUM_WIDTH       = SQ_WIDTH + 2;

    localparam int IN_FIELD_WIDTH  = 3 * COORD_WIDTH + RADIUS_WIDTH;
    localparam int IN_TDATA_WIDTH  = ((IN_FIELD_WIDTH + 7) / 8) * 8;
    localparam int OUT_FIELD_WIDTH = 3 + OUT_COUNT_WIDTH;
    localparam int OUT_TDATA_WIDTH = ((OUT_FIELD_WIDTH + 7) / 8) * 8;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_CHECK_INSERT = 2'd0;
    localparam kind_t KIND_INSERT       = 2'd1;
    localparam kind_t KIND_CHECK_ONLY   = 2'd2;
    localparam kind_t KIND_CLEAR        = 2'd3;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic commit;
    } sot_cmd_t;

    typedef struct packed {
        logic needs_scan;
        logic scan_last;
        logic pipe_empty;
        logic out_free;
    } sot_status_t;

    typedef struct packed {
        logic [RADIUS_WIDTH-1:0] r;
        logic [COORD_WIDTH-1:0]  z;
        logic [COORD_WIDTH-1:0]  y;
        logic [COORD_WIDTH-1:0]  x;
    } sphere_t;

endpackage

// File: rtl/sot_dp.sv
`timescale 1ns / 1ps
`include "sphere_overlap_insert_table_core_macros.svh"

module sot_dp
    import sot_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [IN_TDATA_WIDTH-1:0]  s_tdata,
    input  kind_t                      s_tuser,
    input  sot_cmd_t                   cmd,
    output sot_status_t                status,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [OUT_TDATA_WIDTH-1:0] m_tdata
);

    function automatic logic [COORD_WIDTH-1:0] abs_diff(
        input logic [COORD_WIDTH-1:0] a,
        input logic [COORD_WIDTH-1:0] b
    );
        logic [COORD_WIDTH:0] d;
        d = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
        abs_diff = d[COORD_WIDTH] ? COORD_WIDTH'(~d + 1'b1) : d[COORD_WIDTH-1:0];
    endfunction

    sphere_t                  mem [TABLE_DEPTH];

    sphere_t                  cand_reg;
    kind_t                    kind_reg;
    logic [COUNT_WIDTH-1:0]   count_reg;
    logic [COUNT_WIDTH-1:0]   count_next;
    logic [ADDR_WIDTH-1:0]    idx_reg;
    logic [ADDR_WIDTH-1:0]    idx_next;
    logic                     ovl_reg;
    logic                     ovl_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [OUT_FIELD_WIDTH-1:0] out_data_reg;
    logic [OUT_FIELD_WIDTH-1:0] out_data_next;

    sphere_t                  rd_reg;
    logic                     v0_reg;
    logic [COORD_WIDTH-1:0]   dx_reg;
    logic [COORD_WIDTH-1:0]   dy_reg;
    logic [COORD_WIDTH-1:0]   dz_reg;
    logic [COORD_WIDTH-1:0]   rs_reg;
    logic                     v1_reg;
    logic [SQ_WIDTH-1:0]      sqx_reg;
    logic [SQ_WIDTH-1:0]      sqy_reg;
    logic [SQ_WIDTH-1:0]      sqz_reg;
    logic [SQ_WIDTH-1:0]      rs2_reg;
    logic                     v2_reg;

    logic [SUM_WIDTH-1:0]     dist2;
    logic                     hit;
    logic                     is_full;
    logic                     want_insert;
    logic                     do_write;
    logic                     res_overlap;
    logic                     res_full;

    // Candidate and kind are captured when a word is accepted.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cand_reg.x <= s_tdata[COORD_WIDTH-1:0];
            cand_reg.y <= s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
            cand_reg.z <= s_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
            cand_reg.r <= s_tdata[IN_FIELD_WIDTH-1:3*COORD_WIDTH];
            kind_reg   <= s_tuser;
        end
    end

    // Sphere memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[count_reg[ADDR_WIDTH-1:0]] <= cand_reg;
        end
        if (cmd.scan_step)
        begin
            rd_reg <= mem[idx_reg];
        end
    end

    // Distance pipeline: differences, then squares, then the compare.
    always_ff @(posedge clk)
    begin
        dx_reg  <= abs_diff(cand_reg.x, rd_reg.x);
        dy_reg  <= abs_diff(cand_reg.y, rd_reg.y);
        dz_reg  <= abs_diff(cand_reg.z, rd_reg.z);
        rs_reg  <= COORD_WIDTH'(cand_reg.r) + COORD_WIDTH'(rd_reg.r);
        sqx_reg <= dx_reg * dx_reg;
        sqy_reg <= dy_reg * dy_reg;
        sqz_reg <= dz_reg * dz_reg;
        rs2_reg <= rs_reg * rs_reg;
    end

    assign dist2 = SUM_WIDTH'(sqx_reg) + SUM_WIDTH'(sqy_reg) + SUM_WIDTH'(sqz_reg);
    assign hit   = dist2 < SUM_WIDTH'(rs2_reg);

    assign is_full     = count_reg == COUNT_WIDTH'(TABLE_DEPTH);
    assign want_insert = (kind_reg == KIND_INSERT)
                         || ((kind_reg == KIND_CHECK_INSERT) && !ovl_reg);
    assign do_write    = cmd.commit && want_insert && !is_full;
    assign res_full    = want_insert && is_full;
    assign res_overlap = (kind_reg inside {KIND_CHECK_INSERT, KIND_CHECK_ONLY}) && ovl_reg;

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.load)
        begin
            idx_next = '0;
        end
        else if (cmd.scan_step)
        begin
            idx_next = idx_reg + 1'b1;
        end

        ovl_next = ovl_reg;
        if (cmd.load)
        begin
            ovl_next = 1'b0;
        end
        else if (v2_reg && hit)
        begin
            ovl_next = 1'b1;
        end

        count_next = count_reg;
        if (cmd.commit && (kind_reg == KIND_CLEAR))
        begin
            count_next = '0;
        end
        else if (do_write)
        begin
            count_next = count_reg + 1'b1;
        end

        out_data_next = out_data_reg;
        if (cmd.commit)
        begin
            out_data_next = {OUT_COUNT_WIDTH'(count_next), res_full, do_write, res_overlap};
        end

        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            ovl_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            ovl_reg       <= ovl_next;
            out_valid_reg <= out_valid_next;
            v0_reg        <= cmd.scan_step;
            v1_reg        <= v0_reg;
            v2_reg        <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign status.needs_scan = (kind_reg inside {KIND_CHECK_INSERT, KIND_CHECK_ONLY})
                               && (count_reg != '0);
    assign status.scan_last  = (COUNT_WIDTH'(idx_reg) + COUNT_WIDTH'(1)) == count_reg;
    assign status.pipe_empty = !v0_reg && !v1_reg && !v2_reg;
    assign status.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_WIDTH'(out_data_reg);

    `SOT_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= COUNT_WIDTH'(TABLE_DEPTH))
    `SOT_ASSERT_SAME(a_scan_in_range, cmd.scan_step, COUNT_WIDTH'(idx_reg) < count_reg)
    `SOT_ASSERT_NEXT(a_insert_count, do_write,
                     count_reg == COUNT_WIDTH'($past(count_reg) + 1'b1))

endmodule

// File: rtl/sot_ctrl.sv
`timescale 1ns / 1ps
`include "sphere_overlap_insert_table_core_macros.svh"

module sot_ctrl
    import sot_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  sot_status_t status,
    output sot_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SETUP  = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready      = state_reg == S_IDLE;
    assign cmd.load      = s_tvalid && s_tready;
    assign cmd.scan_step = state_reg == S_SCAN;
    assign cmd.commit    = (state_reg == S_COMMIT) && status.out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                state_next = status.needs_scan ? S_SCAN : S_COMMIT;
            end
            S_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (status.pipe_empty)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `SOT_ASSERT_NEXT(a_scan_to_drain, (state_reg == S_SCAN) && status.scan_last,
                     state_reg == S_DRAIN)
    `SOT_ASSERT_NEXT(a_commit_to_idle, cmd.commit, state_reg == S_IDLE)

endmodule

// File: rtl/sphere_overlap_insert_table_core.sv
// Sphere overlap table. Spheres arrive as words on the s_ channel: tdata carries the
// centre and radius in fixed point with 10 fraction bits, and tuser carries the kind
// (check then insert, insert unchecked, check only, clear). Every accepted word yields
// exactly one result word on the m_ channel with the overlap, inserted and full flags
// and the number of spheres held afterwards.
// A check reads the stored spheres one per cycle from the memory and runs them through
// a four-stage distance pipeline (read, difference, square, compare). A checking word
// moves from setup through the scan and a drain of the pipeline to commit, where its
// result is registered; unchecked inserts, clears and checks of an empty table go from
// setup straight to commit. The block takes one word at a time and is ready again in
// the cycle after the result is registered.
// The result sits in an output register; a new word is accepted while it waits, but the
// next result is held back until the receiver takes the pending one.
// Reset empties the table and clears both channels; the sphere memory is not cleared.
`timescale 1ns / 1ps

module sphere_overlap_insert_table_core
    import sot_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // center_x, center_y, center_z, sphere_radius, zero fill
    input  logic [IN_TDATA_WIDTH-1:0]  s_tdata,
    // kind
    input  kind_t                      s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // overlap_found, was_inserted, table_full, stored_count, zero fill
    output logic [OUT_TDATA_WIDTH-1:0] m_tdata
);

    sot_cmd_t    cmd;
    sot_status_t status;

    sot_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sot_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
